[sv/bdq_pkg.sv]
// Shared types and constants for the bounded deque with positional delete.
`default_nettype none
package bdq_pkg;

   localparam int DEPTH_DEFAULT = 16;
   localparam int WORD_W        = 32;
   localparam int POS_W         = 8;
   localparam int FUNC_W        = 3;

   localparam logic [FUNC_W-1:0] FUNC_INSERT    = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_DEL_FRONT = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_DEL_BACK  = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_DEL_POS   = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_READ_FWD  = 3'd4;
   localparam logic [FUNC_W-1:0] FUNC_READ_REV  = 3'd5;

   typedef enum logic [2:0] {
      OP_INSERT,
      OP_DEL_FRONT,
      OP_DEL_BACK,
      OP_DEL_POS,
      OP_READ_FWD,
      OP_READ_REV,
      OP_NOP
   } op_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_EMPTY    = 2'd1,
      ST_WRONGPOS = 2'd2,
      ST_FULL     = 2'd3
   } status_type;

   typedef struct packed {
      op_type                    op;
      logic signed [WORD_W-1:0]  value;
      logic [POS_W-1:0]          position;
   } cmd_type;

endpackage
`default_nettype wire

[sv/bdq_front.sv]
// Front end: accepts request items, decodes the command and queues it for the back end.
`default_nettype none
module bdq_front (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   input  wire logic [2:0]                       req_func,
   input  wire logic signed [31:0]               req_value,
   input  wire logic [7:0]                       req_position,
   output logic                                  cmd_valid,
   output bdq_pkg::cmd_type                      cmd,
   input  wire logic                             cmd_pop
);
   import bdq_pkg::*;

   cmd_type    slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;
   cmd_type    decoded;
   logic       push;

   always_comb begin
      decoded.value    = req_value;
      decoded.position = req_position;
      case (req_func)
         FUNC_INSERT:    decoded.op = OP_INSERT;
         FUNC_DEL_FRONT: decoded.op = OP_DEL_FRONT;
         FUNC_DEL_BACK:  decoded.op = OP_DEL_BACK;
         FUNC_DEL_POS:   decoded.op = OP_DEL_POS;
         FUNC_READ_FWD:  decoded.op = OP_READ_FWD;
         FUNC_READ_REV:  decoded.op = OP_READ_REV;
         default:        decoded.op = OP_NOP;
      endcase
   end

   assign req_tready = (fill_ff != 2'd2);
   assign push       = req_tvalid && req_tready;
   assign cmd_valid  = (fill_ff != 2'd0);
   assign cmd        = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = cmd_pop ? ~rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + {1'b0, push} - {1'b0, cmd_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= decoded;
      end
   end

endmodule
`default_nettype wire

[sv/bdq_back.sv]
// Back end: holds the ordered entry array, executes commands and drives result items.
`default_nettype none
module bdq_back #(
   parameter int DEPTH = bdq_pkg::DEPTH_DEFAULT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              cmd_valid,
   input  wire bdq_pkg::cmd_type  cmd,
   output logic                   cmd_pop,
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   output logic [1:0]             rsp_status,
   output logic                   rsp_data_valid,
   output logic [31:0]            rsp_data,
   output logic                   rsp_last
);
   import bdq_pkg::*;

   localparam int CW = $clog2(DEPTH + 1);
   localparam int IW = $clog2(DEPTH);
   localparam int PW = (CW > POS_W) ? CW : POS_W;

   typedef enum logic {
      S_IDLE,
      S_READ
   } state_type;

   state_type         state_ff, state_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [IW-1:0]     idx_ff, idx_in;
   logic [WORD_W-1:0] entries_ff [DEPTH];
   logic [WORD_W-1:0] entries_in [DEPTH];
   logic              valid_ff, valid_in;
   status_type        status_ff, status_in;
   logic              dv_ff, dv_in;
   logic [WORD_W-1:0] data_ff, data_in;
   logic              last_ff, last_in;

   logic              out_free;
   logic [PW-1:0]     pos_ext;
   logic [PW-1:0]     count_ext;
   logic [IW-1:0]     sel;
   logic [IW-1:0]     count_m1;

   assign out_free  = !valid_ff || rsp_tready;
   assign pos_ext   = PW'(cmd.position);
   assign count_ext = PW'(count_ff);
   assign count_m1  = IW'(count_ff - CW'(1));
   assign sel       = (cmd.op == OP_READ_REV) ? (count_m1 - idx_ff) : idx_ff;

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      idx_in    = idx_ff;
      entries_in = entries_ff;
      valid_in  = valid_ff && !rsp_tready;
      status_in = status_ff;
      dv_in     = dv_ff;
      data_in   = data_ff;
      last_in   = last_ff;
      cmd_pop   = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (cmd_valid && out_free) begin
               if ((cmd.op == OP_READ_FWD || cmd.op == OP_READ_REV) &&
                   count_ff != CW'(0)) begin
                  state_in = S_READ;
                  idx_in   = IW'(0);
               end else begin
                  cmd_pop   = 1'b1;
                  valid_in  = 1'b1;
                  status_in = ST_OK;
                  dv_in     = 1'b0;
                  data_in   = '0;
                  last_in   = 1'b1;
                  case (cmd.op)
                     OP_INSERT: begin
                        if (count_ff == CW'(DEPTH)) begin
                           status_in = ST_FULL;
                        end else begin
                           entries_in[0] = cmd.value;
                           for (int j = 1; j < DEPTH; j++) begin
                              entries_in[j] = entries_ff[j-1];
                           end
                           count_in = count_ff + CW'(1);
                        end
                     end
                     OP_DEL_FRONT: begin
                        if (count_ff == CW'(0)) begin
                           status_in = ST_EMPTY;
                        end else begin
                           for (int j = 0; j < DEPTH - 1; j++) begin
                              entries_in[j] = entries_ff[j+1];
                           end
                           count_in = count_ff - CW'(1);
                        end
                     end
                     OP_DEL_BACK: begin
                        if (count_ff == CW'(0)) begin
                           status_in = ST_EMPTY;
                        end else begin
                           count_in = count_ff - CW'(1);
                        end
                     end
                     OP_DEL_POS: begin
                        if (count_ff == CW'(0)) begin
                           status_in = ST_EMPTY;
                        end else if (pos_ext == PW'(0) || pos_ext > count_ext) begin
                           status_in = ST_WRONGPOS;
                        end else begin
                           for (int j = 0; j < DEPTH - 1; j++) begin
                              if (PW'(j) >= pos_ext - PW'(1)) begin
                                 entries_in[j] = entries_ff[j+1];
                              end
                           end
                           count_in = count_ff - CW'(1);
                        end
                     end
                     OP_READ_FWD, OP_READ_REV: begin
                        status_in = ST_EMPTY;
                     end
                     default: begin
                        status_in = ST_OK;
                     end
                  endcase
               end
            end
         end
         S_READ: begin
            if (out_free) begin
               valid_in  = 1'b1;
               status_in = ST_OK;
               dv_in     = 1'b1;
               data_in   = entries_ff[sel];
               last_in   = (idx_ff == count_m1);
               if (idx_ff == count_m1) begin
                  cmd_pop  = 1'b1;
                  state_in = S_IDLE;
               end else begin
                  idx_in = idx_ff + IW'(1);
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      entries_ff <= entries_in;
      status_ff  <= status_in;
      dv_ff      <= dv_in;
      data_ff    <= data_in;
      last_ff    <= last_in;
   end

   assign rsp_tvalid     = valid_ff;
   assign rsp_status     = status_ff;
   assign rsp_data_valid = dv_ff;
   assign rsp_data       = data_ff;
   assign rsp_last       = last_ff;

endmodule
`default_nettype wire

[sv/bounded_deque_positional_delete.sv]
// Top level of the bounded deque with positional delete.
// An update item gives its single result item, registered in the back end after the command leaves the front-end queue.
// Updates sustain one item per cycle through the two-entry command queue while the result side is not stalled.
// A readout of N entries gives one entry per cycle from the entry array while the result side is not stalled.
// Synchronous reset empties the list and the command queue; entry words are not cleared.
`default_nettype none
module bounded_deque_positional_delete #(
   parameter int DEPTH = bdq_pkg::DEPTH_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [39:0] req_tdata,  // value[31:0], position[39:32]
   input  wire logic [2:0]  req_tuser,  // func[2:0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,  // data[31:0]
   output logic [2:0]       rsp_tuser,  // status[1:0], data_valid[2]
   output logic             rsp_tlast
);
   import bdq_pkg::*;

   logic       cmd_valid;
   cmd_type    cmd;
   logic       cmd_pop;
   logic [1:0] status;
   logic       data_valid;

   bdq_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_func     (req_tuser),
      .req_value    (req_tdata[31:0]),
      .req_position (req_tdata[39:32]),
      .cmd_valid    (cmd_valid),
      .cmd          (cmd),
      .cmd_pop      (cmd_pop)
   );

   bdq_back #(
      .DEPTH (DEPTH)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .cmd_valid      (cmd_valid),
      .cmd            (cmd),
      .cmd_pop        (cmd_pop),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_status     (status),
      .rsp_data_valid (data_valid),
      .rsp_data       (rsp_tdata),
      .rsp_last       (rsp_tlast)
   );

   assign rsp_tuser = {data_valid, status};

   a_pop_has_cmd: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> cmd_valid)
      else $error("Command popped from an empty queue.");

   a_full_queue_busy: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> cmd_valid)
      else $error("Queue reports full but offers no command.");

   a_update_single: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser[2]) |-> (rsp_tlast && rsp_tdata == 32'd0))
      else $error("Status item without last flag or with nonzero data.");

   a_readout_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[2]) |-> (rsp_tuser[1:0] == ST_OK))
      else $error("Readout item with a non-ok status.");

endmodule
`default_nettype wire

[test/tb.sv]
// Self-checking testbench for the bounded deque: directed table, then weighted random commands.
`default_nettype none
module tb;
   import bdq_pkg::*;

   localparam int DEPTH          = DEPTH_DEFAULT;
   localparam int RANDOM_ITEMS   = 410;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int MAX_REPORTS    = 40;
   localparam int END_CYCLES     = 40;

   // Command codes the block treats as no-ops.
   localparam logic [FUNC_W-1:0] FUNC_SPARE_A = 3'd6;
   localparam logic [FUNC_W-1:0] FUNC_SPARE_B = 3'd7;

   typedef struct {
      status_type  status;
      logic        data_valid;
      logic [31:0] data;
      logic        last;
   } deque_rsp_type;

   typedef struct {
      logic [2:0]  func;
      logic [31:0] value;
      logic [7:0]  position;
      int          reps;
      bit          typed;
      status_type  status;
   } dir_row_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [39:0] req_tdata;   // value[31:0], position[39:32]
   logic [2:0]  req_tuser;   // func[2:0]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;   // data[31:0]
   logic [2:0]  rsp_tuser;   // status[1:0], data_valid[2]
   logic        rsp_tlast;

   logic [31:0]   deque_words [DEPTH];
   int            deque_count;
   deque_rsp_type expected_rsp [$];
   dir_row_type   dir_rows [$];
   int            error_count;
   int            idle_cycles;
   int            req_idle_pct;
   int            rsp_stall_pct;

   bounded_deque_positional_delete #(.DEPTH(DEPTH)) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #10 clock = ~clock;

   task automatic predict_deque(input logic [2:0] func, input logic [31:0] value,
                                input logic [7:0] position);
      deque_rsp_type r;
      int            i;
      int            del_idx;
      r.status     = ST_OK;
      r.data_valid = 1'b0;
      r.data       = '0;
      r.last       = 1'b1;
      del_idx      = -1;
      case (func)
         FUNC_INSERT: begin
            if (deque_count >= DEPTH) begin
               r.status = ST_FULL;
            end else begin
               for (i = deque_count; i > 0; i--) deque_words[i] = deque_words[i-1];
               deque_words[0] = value;
               deque_count++;
            end
         end
         FUNC_DEL_FRONT: begin
            if (deque_count == 0) r.status = ST_EMPTY;
            else del_idx = 0;
         end
         FUNC_DEL_BACK: begin
            if (deque_count == 0) r.status = ST_EMPTY;
            else deque_count--;
         end
         FUNC_DEL_POS: begin
            if (deque_count == 0) r.status = ST_EMPTY;
            else if (position == 0 || int'(position) > deque_count) r.status = ST_WRONGPOS;
            else del_idx = int'(position) - 1;
         end
         FUNC_READ_FWD, FUNC_READ_REV: begin
            if (deque_count == 0) r.status = ST_EMPTY;
         end
         default: ;
      endcase
      if (del_idx >= 0) begin
         for (i = del_idx; i + 1 < deque_count; i++) deque_words[i] = deque_words[i+1];
         deque_count--;
      end
      if ((func == FUNC_READ_FWD || func == FUNC_READ_REV) && deque_count > 0) begin
         for (i = 0; i < deque_count; i++) begin
            r.status     = ST_OK;
            r.data_valid = 1'b1;
            r.data       = (func == FUNC_READ_FWD) ? deque_words[i]
                                                   : deque_words[deque_count-1-i];
            r.last       = (i == deque_count - 1);
            expected_rsp.push_back(r);
         end
      end else begin
         expected_rsp.push_back(r);
      end
   endtask

   // Called at a falling edge; returns at the falling edge after the item is accepted.
   task automatic send_item(input logic [2:0] func, input logic [31:0] value,
                            input logic [7:0] position, input bit typed,
                            input status_type status);
      deque_rsp_type r;
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= func;
      req_tdata  <= {position, value};
      do @(posedge clock); while (!req_tready);
      predict_deque(func, value, position);
      if (typed) begin
         void'(expected_rsp.pop_back());
         r = '{status, 1'b0, 32'd0, 1'b1};
         expected_rsp.push_back(r);
      end
      @(negedge clock);
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (expected_rsp.size() != 0);
   endtask

   function automatic void add_row(input logic [2:0] func, input logic [31:0] value,
                                   input logic [7:0] position, input int reps,
                                   input bit typed, input status_type status);
      dir_row_type row;
      row = '{func, value, position, reps, typed, status};
      dir_rows.push_back(row);
   endfunction

   task automatic report_mismatch(input string field, input logic [31:0] exp_val,
                                  input logic [31:0] act_val);
      error_count++;
      if (error_count <= MAX_REPORTS)
         $display("%0t: %s mismatch, expected %h, actual %h", $time, field, exp_val, act_val);
   endtask

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= rsp_stall_pct);
   end

   always @(posedge clock) begin : rsp_monitor
      deque_rsp_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_rsp.size() == 0) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
               $display("%0t: unexpected item, expected none, actual data %h user %h last %b",
                        $time, rsp_tdata, rsp_tuser, rsp_tlast);
         end else begin
            e = expected_rsp.pop_front();
            if (rsp_tuser[1:0] !== e.status)
               report_mismatch("status", 32'(e.status), 32'(rsp_tuser[1:0]));
            if (rsp_tuser[2] !== e.data_valid)
               report_mismatch("data_valid", 32'(e.data_valid), 32'(rsp_tuser[2]));
            if (rsp_tdata !== e.data) report_mismatch("data", e.data, rsp_tdata);
            if (rsp_tlast !== e.last)
               report_mismatch("last", 32'(e.last), 32'(rsp_tlast));
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles = idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb failed");
            $finish;
         end
      end
   end

   initial begin
      int          n;
      int          r;
      int          ins_pct;
      logic [2:0]  func;
      logic [31:0] value;
      logic [7:0]  position;

      clock         = 1'b0;
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      req_tuser     = '0;
      rsp_tready    = 1'b0;
      deque_count   = 0;
      error_count   = 0;
      idle_cycles   = 0;
      req_idle_pct  = 27;
      rsp_stall_pct = 66;
      foreach (deque_words[i]) deque_words[i] = '0;

      // Empty list: every delete and readout reports empty, position check included.
      add_row(FUNC_READ_FWD,  32'h0,        8'd0,   1, 1, ST_EMPTY);
      add_row(FUNC_DEL_FRONT, 32'h0,        8'd0,   1, 1, ST_EMPTY);
      add_row(FUNC_DEL_BACK,  32'h0,        8'd0,   1, 1, ST_EMPTY);
      add_row(FUNC_DEL_POS,   32'h0,        8'd5,   1, 1, ST_EMPTY);
      add_row(FUNC_READ_REV,  32'h0,        8'd0,   1, 1, ST_EMPTY);
      add_row(FUNC_INSERT,    32'h80000000, 8'd0,   1, 1, ST_OK);
      add_row(FUNC_INSERT,    32'h7fffffff, 8'd0,   1, 1, ST_OK);
      add_row(FUNC_INSERT,    32'h00000000, 8'd0,   1, 1, ST_OK);
      add_row(FUNC_INSERT,    32'hffffffff, 8'd0,   1, 1, ST_OK);
      add_row(FUNC_DEL_POS,   32'h0,        8'd0,   1, 1, ST_WRONGPOS);
      add_row(FUNC_DEL_POS,   32'h0,        8'd255, 1, 1, ST_WRONGPOS);
      add_row(FUNC_DEL_POS,   32'h0,        8'd5,   1, 1, ST_WRONGPOS);
      add_row(FUNC_READ_FWD,  32'h0,        8'd0,   1, 0, ST_OK);
      add_row(FUNC_READ_REV,  32'h0,        8'd0,   1, 0, ST_OK);
      add_row(FUNC_DEL_POS,   32'h0,        8'd4,   1, 0, ST_OK);
      add_row(FUNC_DEL_POS,   32'h0,        8'd1,   1, 0, ST_OK);
      add_row(FUNC_SPARE_A,   32'hffffffff, 8'd255, 1, 1, ST_OK);
      add_row(FUNC_SPARE_B,   32'h5a5a5a5a, 8'd3,   1, 1, ST_OK);
      // Fill to capacity, then one insert too many.
      add_row(FUNC_INSERT,    32'h12345670, 8'd0,  14, 0, ST_OK);
      add_row(FUNC_INSERT,    32'hdeadbeef, 8'd0,   1, 1, ST_FULL);
      add_row(FUNC_READ_FWD,  32'h0,        8'd0,   1, 0, ST_OK);
      add_row(FUNC_DEL_POS,   32'h0,        8'd16,  1, 0, ST_OK);
      add_row(FUNC_DEL_BACK,  32'h0,        8'd0,   1, 0, ST_OK);
      add_row(FUNC_DEL_POS,   32'h0,        8'd7,   1, 0, ST_OK);
      add_row(FUNC_READ_REV,  32'h0,        8'd0,   1, 0, ST_OK);

      repeat (10) @(negedge clock);
      reset <= 1'b0;

      foreach (dir_rows[k]) begin
         for (int j = 0; j < dir_rows[k].reps; j++)
            send_item(dir_rows[k].func, dir_rows[k].value + j, dir_rows[k].position,
                      dir_rows[k].typed, dir_rows[k].status);
      end
      drain_results();

      for (n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == RANDOM_ITEMS / 3) begin
            drain_results();
            req_idle_pct  = 66;
            rsp_stall_pct = 27;
         end else if (n == 2 * RANDOM_ITEMS / 3) begin
            drain_results();
            req_idle_pct  = 0;
            rsp_stall_pct = 0;
         end
         // Alternate stretches that fill the list and stretches that empty it.
         ins_pct  = ((n / 40) % 2 == 0) ? 50 : 15;
         r        = $urandom_range(0, 99);
         value    = $urandom();
         position = 8'($urandom_range(0, 255));
         if (r < ins_pct) begin
            func = FUNC_INSERT;
         end else if (r < ins_pct + 10) begin
            func = FUNC_DEL_FRONT;
         end else if (r < ins_pct + 20) begin
            func = FUNC_DEL_BACK;
         end else if (r < ins_pct + 44) begin
            func = FUNC_READ_FWD;
            if (r < ins_pct + 40) begin
               func = FUNC_DEL_POS;
               if (deque_count > 0 && $urandom_range(0, 99) < 80)
                  position = 8'($urandom_range(1, deque_count));
            end
         end else if (r < ins_pct + 48) begin
            func = FUNC_READ_REV;
         end else if (r < ins_pct + 50) begin
            func = $urandom_range(0, 1) ? FUNC_SPARE_A : FUNC_SPARE_B;
         end else begin
            func = FUNC_DEL_POS;
            if (deque_count > 0) position = 8'($urandom_range(1, deque_count));
         end
         send_item(func, value, position, 0, ST_OK);
      end

      drain_results();
      repeat (END_CYCLES) @(negedge clock);
      if (error_count == 0 && expected_rsp.size() == 0) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end

endmodule
`default_nettype wire

[sim.f]
sv/bdq_pkg.sv
sv/bdq_front.sv
sv/bdq_back.sv
sv/bounded_deque_positional_delete.sv
test/tb.sv
